[design/pfp_pkg.sv]
// Package for the preamble frame parser: sizes, CRC constants and shared types.
// No dependencies; every other file but pfp_ram imports it.
package pfp_pkg;

  localparam int MAX_PAYLOAD    = 32;
  localparam int PREAMBLE_BYTES = 4;
  localparam int POS_W          = $clog2(PREAMBLE_BYTES);
  localparam int IDX_W          = $clog2(MAX_PAYLOAD);
  localparam int CNT_W          = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W          = 6;
  localparam int BUF_DEPTH      = 2 * MAX_PAYLOAD;
  localparam int BUF_AW         = $clog2(BUF_DEPTH);

  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [31:0] PREAMBLE_RESET = 32'hDDCCBBAA;

  typedef struct packed {
    logic [7:0]       src;
    logic [LEN_W-1:0] len;
    logic             bank;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

[design/pfp_in_if.sv]
// Receive byte channel: valid/ready handshake with one byte of payload.
// Depends on pfp_pkg.
interface pfp_in_if import pfp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[design/pfp_out_if.sv]
// Result channel: one beat per payload byte of an accepted frame, or one beat for an empty frame.
// Depends on pfp_pkg for the length width.
interface pfp_out_if import pfp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       source_address;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       payload_byte;
  logic             last_of_frame;

  modport source (output valid, output source_address, output payload_length,
                  output payload_byte, output last_of_frame, input ready);
  modport sink (input valid, input source_address, input payload_length,
                input payload_byte, input last_of_frame, output ready);
endinterface

[design/pfp_cfg_if.sv]
// Configuration write channel carrying the preamble register value.
// Depends on pfp_pkg.
interface pfp_cfg_if import pfp_pkg::*;;
  logic        valid;
  logic        ready;
  logic [31:0] preamble_word;

  modport source (output valid, output preamble_word, input ready);
  modport sink (input valid, input preamble_word, output ready);
endinterface

[design/pfp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/pfp_desc_fifo.sv]
// Two-entry queue of accepted frame descriptors between parser and emitter.
// Depends on pfp_pkg.
module pfp_desc_fifo import pfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_desc,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output frame_desc_t head_desc
);

  frame_desc_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_desc  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_desc;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[design/pfp_front.sv]
// Front end: preamble hunt, header parse, payload buffering and CRC-32 check.
// Depends on pfp_pkg and the rx/cfg channel interfaces.
module pfp_front import pfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pfp_in_if.sink        rx,
  pfp_cfg_if.sink       cfg,
  input  logic          fifo_full,
  output logic          push,
  output frame_desc_t   push_desc,
  output buf_wr_t       buf_wr
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  logic [2:0]       phase;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       src_reg;
  logic [LEN_W-1:0] len_reg;
  logic [31:0]      running_crc;
  logic [31:0]      received_crc;
  logic             wr_bank;
  logic [31:0]      preamble_word;

  logic             accept;
  logic [7:0]       b;
  logic [LEN_W-1:0] size_clamped;
  logic [CNT_W-1:0] cnt_inc;
  logic [POS_W-1:0] pos;
  logic [7:0]       want;
  logic [31:0]      rx_crc_next;
  logic [31:0]      crc_next;

  assign rx.ready  = !fifo_full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;

  assign size_clamped = (b > 8'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : b[LEN_W-1:0];
  assign cnt_inc      = byte_count + CNT_W'(1);
  assign pos          = byte_count[POS_W-1:0];
  assign want         = preamble_word[{pos, 3'b000} +: 8];
  assign rx_crc_next  = received_crc | ({24'd0, b} << {byte_count[1:0], 3'b000});
  assign crc_next     = crc_byte(running_crc, (phase == PH_SIZE) ? 8'(size_clamped) : b);

  assign push = accept && (phase == PH_CRC) && (byte_count[1:0] == 2'd3)
                && ((running_crc ^ CRC_INIT) == rx_crc_next);
  assign push_desc = '{src: src_reg, len: len_reg, bank: wr_bank};

  assign buf_wr.en   = accept && (phase == PH_DATA);
  assign buf_wr.addr = {wr_bank, byte_count[IDX_W-1:0]};
  assign buf_wr.data = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_count    <= '0;
      src_reg       <= '0;
      len_reg       <= '0;
      running_crc   <= CRC_INIT;
      received_crc  <= '0;
      wr_bank       <= 1'b0;
      preamble_word <= PREAMBLE_RESET;
    end else begin
      if (cfg.valid) begin
        preamble_word <= cfg.preamble_word;
      end
      if (push) begin
        wr_bank <= ~wr_bank;
      end
      if (accept) begin
        case (phase)
          PH_ADDR: begin
            running_crc <= crc_next;
            if (byte_count == '0) begin
              byte_count <= CNT_W'(1);
            end else begin
              src_reg    <= b;
              byte_count <= '0;
              phase      <= PH_SIZE;
            end
          end
          PH_SIZE: begin
            len_reg     <= size_clamped;
            running_crc <= crc_next;
            byte_count  <= '0;
            phase       <= (size_clamped == '0) ? PH_CRC : PH_DATA;
          end
          PH_DATA: begin
            running_crc <= crc_next;
            if (cnt_inc >= CNT_W'(len_reg)) begin
              byte_count <= '0;
              phase      <= PH_CRC;
            end else begin
              byte_count <= cnt_inc;
            end
          end
          PH_CRC: begin
            received_crc <= rx_crc_next;
            if (byte_count[1:0] == 2'd3) begin
              phase       <= PH_HUNT;
              byte_count  <= '0;
              running_crc <= CRC_INIT;
            end else begin
              byte_count <= cnt_inc;
            end
          end
          default: begin
            phase <= PH_HUNT;
            if (b == want) begin
              running_crc <= crc_next;
              if (pos == POS_W'(PREAMBLE_BYTES - 1)) begin
                byte_count   <= '0;
                received_crc <= '0;
                phase        <= PH_ADDR;
              end else begin
                byte_count <= CNT_W'(pos) + CNT_W'(1);
              end
            end else begin
              byte_count  <= '0;
              running_crc <= CRC_INIT;
            end
          end
        endcase
      end
    end
  end

endmodule

[design/pfp_back.sv]
// Back end: walks queued frames, reads the payload buffer and emits result beats.
// Depends on pfp_pkg and the result channel interface.
module pfp_back import pfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  frame_desc_t       head_desc,
  output logic              pop,
  output logic              rd_en,
  output logic [BUF_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  pfp_out_if.source         result
);

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_inc;
  logic [CNT_W-1:0] beats;
  logic             is_last;
  logic             issue;
  logic             s1_move;

  logic             s1_valid;
  logic [7:0]       s1_src;
  logic [LEN_W-1:0] s1_len;
  logic             s1_zero;
  logic             s1_last;

  assign k_inc   = k + CNT_W'(1);
  assign beats   = (head_desc.len == '0) ? CNT_W'(1) : CNT_W'(head_desc.len);
  assign is_last = k_inc == beats;
  assign s1_move = s1_valid && (!result.valid || result.ready);
  assign issue   = head_valid && (!s1_valid || s1_move);
  assign pop     = issue && is_last;
  assign rd_en   = issue && (head_desc.len != '0);
  assign rd_addr = {head_desc.bank, k[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      k            <= '0;
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= is_last ? '0 : k_inc;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_src  <= head_desc.src;
      s1_len  <= head_desc.len;
      s1_zero <= head_desc.len == '0;
      s1_last <= is_last;
    end
    if (s1_move) begin
      result.source_address <= s1_src;
      result.payload_length <= s1_len;
      result.payload_byte   <= s1_zero ? 8'd0 : rd_data;
      result.last_of_frame  <= s1_last;
    end
  end

endmodule

[design/preamble_frame_parser_crc32.sv]
// Preamble/length/CRC-32 frame parser. Accepts one byte per cycle; the parser
// stalls input only while two checked frames wait in the descriptor queue.
// Each checked frame is queued; its bytes go from the buffer RAM's single read port
// through s1 to the result register, one beat per cycle while result.ready is high.
// Reset (synchronous): hunt for preamble, preamble register 0xDDCCBBAA, queue empty.
// The payload buffer is not cleared.
module preamble_frame_parser_crc32 import pfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  pfp_in_if.sink    rx,
  pfp_cfg_if.sink   cfg,
  pfp_out_if.source result
);

  logic              push;
  frame_desc_t       push_desc;
  logic              fifo_full;
  logic              pop;
  logic              head_valid;
  frame_desc_t       head_desc;
  buf_wr_t           buf_wr;
  logic              rd_en;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  pfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .push      (push),
    .push_desc (push_desc),
    .buf_wr    (buf_wr)
  );

  pfp_desc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  pfp_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_wr.en),
    .waddr (buf_wr.addr),
    .wdata (buf_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .result     (result)
  );

endmodule
